// ===== rtl/ndd_pkg.sv =====
// Shared types and constants for the Newton divided-difference interpolator.
// No dependencies; imported by the channel interfaces and the top level.
package ndd_pkg;

   localparam int MAX_NODES = 16;
   localparam int IDX_W     = $clog2(MAX_NODES);
   localparam int CNT_W     = $clog2(MAX_NODES + 1);

   localparam int DIV_STEPS = 49;
   localparam int MUL_STEPS = 33;
   localparam int STEP_W    = 6;

   typedef enum logic {
      ACT_LOAD = 1'b0,
      ACT_EVAL = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_DUP_X   = 2'd1,
      ST_FULL    = 2'd2,
      ST_UNBUILT = 2'd3
   } status_type;

   typedef struct packed {
      logic               action;
      logic signed [31:0] node_x;
      logic signed [31:0] node_y;
      logic               last_node;
      logic signed [31:0] query_x;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic [1:0]         status;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_B_RDA,
      S_B_RDB,
      S_B_PREP,
      S_B_DIV,
      S_B_WR,
      S_E_RDP,
      S_E_CAPP,
      S_E_RD,
      S_E_PREP,
      S_E_MUL,
      S_E_ACC,
      S_OUT
   } state_type;

endpackage

// ===== rtl/ndd_if.sv =====
// Valid/ready channel interfaces for requests and responses.
// Depends on ndd_pkg for the payload types.
interface ndd_req_if import ndd_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface ndd_rsp_if import ndd_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/newton_divided_difference_interp.sv =====
// Newton divided-difference interpolator, signed Q16.16, one request at a time.
// Load without last_node: response registered in the cycle after accept. Load with last_node
// on n nodes builds the divided differences through the shared bit-serial divide (49 steps per
// coefficient). Evaluate runs Horner steps through the 33-step shift-add multiply.
// Synchronous reset clears node count, built flag, sequencer and response valid;
// node stores are not cleared and hold garbage until loaded.
module newton_divided_difference_interp import ndd_pkg::*; (
   input logic        clock,
   input logic        reset,
   ndd_req_if.sink    req_chan,
   ndd_rsp_if.source  rsp_chan
);

   // node stores: one write and one registered read per cycle each
   logic [31:0] x_mem [MAX_NODES];
   logic [31:0] c_mem [MAX_NODES];
   logic [31:0] x_rd_ff, c_rd_ff;
   logic [IDX_W-1:0] x_raddr, c_raddr;
   logic             x_we, c_we;
   logic [IDX_W-1:0] x_waddr, c_waddr;
   logic [31:0]      x_wdata, c_wdata;

   // sequencer and datapath registers
   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 built_ff, built_in;
   logic [IDX_W-1:0]     i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic signed [31:0]   query_ff, query_in;
   logic signed [31:0]   p_ff, p_in;
   logic signed [31:0]   ca_ff, ca_in;
   logic signed [31:0]   xa_ff, xa_in;
   logic                 sign_ff, sign_in;
   logic [1:0]           stat_ff, stat_in;
   logic [65:0]          work_ff, work_in;
   logic [48:0]          shreg_ff, shreg_in;
   logic [32:0]          opnd_ff, opnd_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   // shared add/subtract unit: restoring divide step or shift-add multiply step
   logic        unit_div;
   logic [65:0] unit_a, unit_b, unit_sum;
   logic [65:0] unit_work;
   logic [48:0] unit_shreg;

   always_comb begin
      if (unit_div) begin
         unit_a = {32'd0, work_ff[32:0], shreg_ff[48]};
         unit_b = {33'd0, opnd_ff};
         unit_sum = unit_a + ~unit_b + 66'd1;
         if (!unit_sum[65]) begin
            unit_work  = unit_sum;
            unit_shreg = {shreg_ff[47:0], 1'b1};
         end else begin
            unit_work  = unit_a;
            unit_shreg = {shreg_ff[47:0], 1'b0};
         end
      end else begin
         unit_a = {work_ff[64:0], 1'b0};
         unit_b = shreg_ff[48] ? {33'd0, opnd_ff} : 66'd0;
         unit_sum   = unit_a + unit_b;
         unit_work  = unit_sum;
         unit_shreg = {shreg_ff[47:0], 1'b0};
      end
   end

   // build and evaluate arithmetic around the unit
   logic signed [32:0] num_d, den_d, q_d;
   logic [32:0]        num_mag, den_mag, q_mag, p_mag;
   logic [31:0]        div_sat;
   logic [48:0]        prod_mag;
   logic signed [50:0] prod_s, horner_sum;
   logic signed [31:0] horner_sat;
   logic [CNT_W-1:0]   eff_count, cnt_m1;

   always_comb begin
      num_d   = {ca_ff[31], ca_ff} - {c_rd_ff[31], c_rd_ff};
      den_d   = {xa_ff[31], xa_ff} - {x_rd_ff[31], x_rd_ff};
      num_mag = num_d[32] ? 33'(-num_d) : 33'(num_d);
      den_mag = den_d[32] ? 33'(-den_d) : 33'(den_d);
      q_d     = {query_ff[31], query_ff} - {x_rd_ff[31], x_rd_ff};
      q_mag   = q_d[32] ? 33'(-q_d) : 33'(q_d);
      p_mag   = p_ff[31] ? 33'(-{p_ff[31], p_ff}) : {1'b0, p_ff};

      // truncated quotient magnitude in shreg, saturate with sign
      if (sign_ff) begin
         if (shreg_ff > 49'h0_8000_0000) div_sat = 32'h8000_0000;
         else                            div_sat = 32'(-shreg_ff[31:0]);
      end else begin
         if (shreg_ff > 49'h0_7FFF_FFFF) div_sat = 32'h7FFF_FFFF;
         else                            div_sat = shreg_ff[31:0];
      end

      // drop the 16 fraction bits of the magnitude, then apply sign
      prod_mag   = work_ff[64:16];
      prod_s     = sign_ff ? -$signed({2'b00, prod_mag}) : $signed({2'b00, prod_mag});
      horner_sum = prod_s + {{19{ca_ff[31]}}, ca_ff};
      if (horner_sum > 51'sd2147483647)       horner_sat = 32'sh7FFF_FFFF;
      else if (horner_sum < -51'sd2147483648) horner_sat = 32'sh8000_0000;
      else                                    horner_sat = horner_sum[31:0];

      eff_count = built_ff ? '0 : count_ff;
      cnt_m1    = count_ff - CNT_W'(1);
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         built_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         built_ff     <= built_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      query_ff    <= query_in;
      p_ff        <= p_in;
      ca_ff       <= ca_in;
      xa_ff       <= xa_in;
      sign_ff     <= sign_in;
      stat_ff     <= stat_in;
      work_ff     <= work_in;
      shreg_ff    <= shreg_in;
      opnd_ff     <= opnd_in;
      step_ff     <= step_in;
      rsp_data_ff <= rsp_data_in;
   end

   // node stores
   always_ff @(posedge clock) begin
      if (x_we) x_mem[x_waddr] <= x_wdata;
      if (c_we) c_mem[c_waddr] <= c_wdata;
      x_rd_ff <= x_mem[x_raddr];
      c_rd_ff <= c_mem[c_raddr];
   end

   assign req_chan.ready   = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // next state, datapath control
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      built_in     = built_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      query_in     = query_ff;
      p_in         = p_ff;
      ca_in        = ca_ff;
      xa_in        = xa_ff;
      sign_in      = sign_ff;
      stat_in      = stat_ff;
      work_in      = work_ff;
      shreg_in     = shreg_ff;
      opnd_in      = opnd_ff;
      step_in      = step_ff;
      rsp_data_in  = rsp_data_ff;
      unit_div     = 1'b1;
      x_we         = 1'b0;
      c_we         = 1'b0;
      x_waddr      = eff_count[IDX_W-1:0];
      c_waddr      = eff_count[IDX_W-1:0];
      x_wdata      = req_chan.payload.node_x;
      c_wdata      = req_chan.payload.node_y;
      x_raddr      = i_ff;
      c_raddr      = i_ff;

      // drop the response once taken
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid && req_chan.ready) begin
               if (req_chan.payload.action == ACT_EVAL) begin
                  if (!built_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '{value: 32'sd0, status: ST_UNBUILT};
                  end else begin
                     query_in = req_chan.payload.query_x;
                     k_in     = cnt_m1[IDX_W-1:0];
                     state_in = S_E_RDP;
                  end
               end else begin
                  // a load always drops a finished interpolant
                  built_in = 1'b0;
                  if (eff_count == CNT_W'(MAX_NODES)) begin
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '{value: 32'sd0, status: ST_FULL};
                  end else begin
                     x_we     = 1'b1;
                     c_we     = 1'b1;
                     count_in = eff_count + CNT_W'(1);
                     if (req_chan.payload.last_node && eff_count != '0) begin
                        j_in     = IDX_W'(1);
                        i_in     = eff_count[IDX_W-1:0];
                        state_in = S_B_RDA;
                     end else begin
                        built_in     = req_chan.payload.last_node;
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '{value: 32'sd0, status: ST_OK};
                     end
                  end
               end
            end
         end

         S_B_RDA: begin
            state_in = S_B_RDB;
         end

         S_B_RDB: begin
            // capture c[i], x[i]; fetch c[i-1], x[i-j]
            ca_in    = c_rd_ff;
            xa_in    = x_rd_ff;
            c_raddr  = i_ff - IDX_W'(1);
            x_raddr  = i_ff - j_ff;
            state_in = S_B_PREP;
         end

         S_B_PREP: begin
            if (den_d == '0) begin
               count_in = '0;
               built_in = 1'b0;
               p_in     = 32'sd0;
               stat_in  = ST_DUP_X;
               state_in = S_OUT;
            end else begin
               work_in  = '0;
               shreg_in = {num_mag, 16'd0};
               opnd_in  = den_mag;
               sign_in  = num_d[32] ^ den_d[32];
               step_in  = STEP_W'(DIV_STEPS);
               state_in = S_B_DIV;
            end
         end

         S_B_DIV: begin
            unit_div = 1'b1;
            work_in  = unit_work;
            shreg_in = unit_shreg;
            step_in  = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) state_in = S_B_WR;
         end

         S_B_WR: begin
            c_we    = 1'b1;
            c_waddr = i_ff;
            c_wdata = div_sat;
            if (i_ff == j_ff) begin
               if (CNT_W'(j_ff) + CNT_W'(1) == count_ff) begin
                  built_in = 1'b1;
                  p_in     = 32'sd0;
                  stat_in  = ST_OK;
                  state_in = S_OUT;
               end else begin
                  j_in     = j_ff + IDX_W'(1);
                  i_in     = cnt_m1[IDX_W-1:0];
                  state_in = S_B_RDA;
               end
            end else begin
               i_in     = i_ff - IDX_W'(1);
               state_in = S_B_RDA;
            end
         end

         S_E_RDP: begin
            c_raddr  = k_ff;
            state_in = S_E_CAPP;
         end

         S_E_CAPP: begin
            p_in = c_rd_ff;
            if (k_ff == '0) begin
               stat_in  = ST_OK;
               state_in = S_OUT;
            end else begin
               state_in = S_E_RD;
            end
         end

         S_E_RD: begin
            c_raddr  = k_ff - IDX_W'(1);
            x_raddr  = k_ff - IDX_W'(1);
            state_in = S_E_PREP;
         end

         S_E_PREP: begin
            ca_in    = c_rd_ff;
            work_in  = '0;
            shreg_in = {q_mag, 16'd0};
            opnd_in  = p_mag;
            sign_in  = p_ff[31] ^ q_d[32];
            step_in  = STEP_W'(MUL_STEPS);
            state_in = S_E_MUL;
         end

         S_E_MUL: begin
            unit_div = 1'b0;
            work_in  = unit_work;
            shreg_in = unit_shreg;
            step_in  = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) state_in = S_E_ACC;
         end

         S_E_ACC: begin
            p_in = horner_sat;
            k_in = k_ff - IDX_W'(1);
            if (k_ff == IDX_W'(1)) begin
               stat_in  = ST_OK;
               state_in = S_OUT;
            end else begin
               state_in = S_E_RD;
            end
         end

         S_OUT: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{value: p_ff, status: stat_ff};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule
